FILE: rtl/ascs_pkg.sv
// ----------------------------------------------------------------------------
// ascs_pkg
// shared types, constants and helpers for the accumulator stack machine
// ----------------------------------------------------------------------------
package ascs_pkg;

	localparam int CORE_DEPTH = 64;
	localparam int DS_DEPTH   = 16;
	localparam int RS_DEPTH   = 16;

	localparam int CORE_AW = $clog2(CORE_DEPTH);
	localparam int DS_AW   = $clog2(DS_DEPTH);
	localparam int RS_AW   = $clog2(RS_DEPTH);

	localparam logic [8:0] CORE_LIMIT = 9'(CORE_DEPTH);

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_EXEC    = 2'd2,
		OP_RESTART = 2'd3
	} oper_t;

	typedef enum logic [2:0] {
		ST_RUN        = 3'd0,
		ST_HALT       = 3'd1,
		ST_PC_RANGE   = 3'd2,
		ST_JEQ_RANGE  = 3'd3,
		ST_JMP_RANGE  = 3'd4,
		ST_LOAD_RANGE = 3'd5,
		ST_STOR_RANGE = 3'd6,
		ST_BAD_OP     = 3'd7
	} stop_t;

	localparam logic [7:0] INS_NOOP  = 8'h00;
	localparam logic [7:0] INS_JMP   = 8'h01;
	localparam logic [7:0] INS_JEQ   = 8'h02;
	localparam logic [7:0] INS_PUSH  = 8'h03;
	localparam logic [7:0] INS_POP   = 8'h04;
	localparam logic [7:0] INS_RPUSH = 8'h05;
	localparam logic [7:0] INS_RPOP  = 8'h06;
	localparam logic [7:0] INS_ADD   = 8'h07;
	localparam logic [7:0] INS_SUB   = 8'h08;
	localparam logic [7:0] INS_LOAD  = 8'h09;
	localparam logic [7:0] INS_STOR  = 8'h0a;
	localparam logic [7:0] INS_HALT  = 8'hff;

	typedef logic [CORE_AW-1:0] core_idx_t;
	typedef logic [DS_AW-1:0]   ds_idx_t;
	typedef logic [RS_AW-1:0]   rs_idx_t;

	typedef struct packed {
		logic [6:0] pc;
		ds_idx_t    dtop;
		rs_idx_t    rtop;
		logic [7:0] acc;
		stop_t      stop;
	} mach_t;

	typedef struct packed {
		logic       en;
		core_idx_t  idx;
		logic [7:0] data;
	} core_wr_t;

	typedef struct packed {
		logic       en;
		ds_idx_t    idx;
		logic [7:0] data;
	} ds_wr_t;

	typedef struct packed {
		logic       en;
		rs_idx_t    idx;
		logic [7:0] data;
	} rs_wr_t;

	function automatic logic in_core(logic [8:0] a);
		return a < CORE_LIMIT;
	endfunction

	function automatic core_idx_t core_idx(logic [8:0] a);
		return a[CORE_AW-1:0];
	endfunction

	function automatic ds_idx_t ds_inc(ds_idx_t p);
		return (p == DS_AW'(DS_DEPTH - 1)) ? '0 : ds_idx_t'(p + 1'b1);
	endfunction

	function automatic ds_idx_t ds_dec(ds_idx_t p);
		return (p == '0) ? DS_AW'(DS_DEPTH - 1) : ds_idx_t'(p - 1'b1);
	endfunction

	function automatic rs_idx_t rs_inc(rs_idx_t p);
		return (p == RS_AW'(RS_DEPTH - 1)) ? '0 : rs_idx_t'(p + 1'b1);
	endfunction

	function automatic rs_idx_t rs_dec(rs_idx_t p);
		return (p == '0) ? RS_AW'(RS_DEPTH - 1) : rs_idx_t'(p - 1'b1);
	endfunction

endpackage

FILE: rtl/ascs_core_mem.sv
// ----------------------------------------------------------------------------
// ascs_core_mem
// core byte memory, one write port, two registered read ports with bypass
// ----------------------------------------------------------------------------
module ascs_core_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ascs_pkg::core_wr_t    wr,
	input  ascs_pkg::core_idx_t   ra_idx,
	input  ascs_pkg::core_idx_t   rb_idx,
	output logic [7:0]            ra_q,
	output logic [7:0]            rb_q
);

	logic [7:0]                      mem [ascs_pkg::CORE_DEPTH];
	logic [ascs_pkg::CORE_DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ra_q  <= '0;
			rb_q  <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (wr.en && wr.idx == ra_idx) begin
				ra_q <= wr.data;
			end else if (vld_q[ra_idx]) begin
				ra_q <= mem[ra_idx];
			end else begin
				ra_q <= '0;
			end
			if (wr.en && wr.idx == rb_idx) begin
				rb_q <= wr.data;
			end else if (vld_q[rb_idx]) begin
				rb_q <= mem[rb_idx];
			end else begin
				rb_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/ascs_dstack.sv
// ----------------------------------------------------------------------------
// ascs_dstack
// data stack memory with cached top, next and bottom entry
// ----------------------------------------------------------------------------
module ascs_dstack (
	input  logic                clk,
	input  logic                arst_n,
	input  ascs_pkg::ds_wr_t    wr,
	input  ascs_pkg::ds_idx_t   top_n,
	input  logic [7:0]          tos_n,
	output logic [7:0]          tos_q,
	output logic [7:0]          nos_q,
	output logic [7:0]          ds0_q
);

	logic [7:0]                    mem [ascs_pkg::DS_DEPTH];
	logic [ascs_pkg::DS_DEPTH-1:0] vld_q;
	ascs_pkg::ds_idx_t             rd_idx;

	assign rd_idx = ascs_pkg::ds_dec(top_n);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			tos_q <= '0;
			nos_q <= '0;
			ds0_q <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			tos_q <= tos_n;
			if (wr.en && wr.idx == rd_idx) begin
				nos_q <= wr.data;
			end else if (vld_q[rd_idx]) begin
				nos_q <= mem[rd_idx];
			end else begin
				nos_q <= '0;
			end
			if (wr.en && wr.idx == '0) begin
				ds0_q <= wr.data;
			end
		end
	end

endmodule

FILE: rtl/ascs_exec.sv
// ----------------------------------------------------------------------------
// ascs_exec
// decode and next-state logic for one transaction
// ----------------------------------------------------------------------------
module ascs_exec (
	input  ascs_pkg::oper_t     op,
	input  logic [5:0]          addr,
	input  logic [7:0]          wdata,
	input  ascs_pkg::mach_t     cur,
	input  logic [7:0]          tos,
	input  logic [7:0]          nos,
	input  logic [7:0]          ds0,
	input  logic [7:0]          rs_val,
	input  logic [7:0]          fetch_data,
	input  logic [7:0]          load_data,
	output ascs_pkg::mach_t     nxt,
	output logic [7:0]          tos_n,
	output ascs_pkg::core_wr_t  core_wr,
	output ascs_pkg::ds_wr_t    ds_wr,
	output ascs_pkg::rs_wr_t    rs_wr,
	output logic [7:0]          rdata
);

	logic [6:0]        pc_inc;
	ascs_pkg::ds_idx_t d_inc;
	ascs_pkg::ds_idx_t d_dec;
	ascs_pkg::rs_idx_t r_inc;
	ascs_pkg::rs_idx_t r_dec;
	logic [7:0]        sum;
	logic [7:0]        diff;
	logic              tos_ok;

	assign pc_inc = cur.pc + 7'd1;
	assign d_inc  = ascs_pkg::ds_inc(cur.dtop);
	assign d_dec  = ascs_pkg::ds_dec(cur.dtop);
	assign r_inc  = ascs_pkg::rs_inc(cur.rtop);
	assign r_dec  = ascs_pkg::rs_dec(cur.rtop);
	assign sum    = nos + tos;
	assign diff   = nos - tos;
	assign tos_ok = ascs_pkg::in_core({1'b0, tos});

	always_comb begin
		nxt     = cur;
		tos_n   = tos;
		core_wr = '0;
		ds_wr   = '0;
		rs_wr   = '0;
		rdata   = '0;
		case (op)
			ascs_pkg::OP_WRITE: begin
				if (ascs_pkg::in_core({3'b000, addr})) begin
					core_wr.en   = 1'b1;
					core_wr.idx  = ascs_pkg::core_idx({3'b000, addr});
					core_wr.data = wdata;
				end
			end
			ascs_pkg::OP_READ: begin
				if (ascs_pkg::in_core({3'b000, addr})) begin
					rdata = fetch_data;
				end
			end
			ascs_pkg::OP_EXEC: begin
				if (cur.stop == ascs_pkg::ST_RUN) begin
					if (!ascs_pkg::in_core({2'b00, cur.pc})) begin
						nxt.stop = ascs_pkg::ST_PC_RANGE;
					end else begin
						nxt.pc = pc_inc;
						case (fetch_data)
							ascs_pkg::INS_NOOP: begin
							end
							ascs_pkg::INS_JMP: begin
								nxt.dtop = d_dec;
								tos_n    = nos;
								if (tos_ok) begin
									nxt.pc = tos[6:0];
								end else begin
									nxt.stop = ascs_pkg::ST_JMP_RANGE;
								end
							end
							ascs_pkg::INS_JEQ: begin
								nxt.dtop = d_dec;
								tos_n    = nos;
								if (cur.acc == '0) begin
									if (tos_ok) begin
										nxt.pc = tos[6:0];
									end else begin
										nxt.stop = ascs_pkg::ST_JEQ_RANGE;
									end
								end
							end
							ascs_pkg::INS_PUSH: begin
								nxt.dtop = d_inc;
								tos_n    = cur.acc;
								ds_wr    = '{en: 1'b1, idx: d_inc, data: cur.acc};
							end
							ascs_pkg::INS_POP: begin
								nxt.dtop = d_dec;
								nxt.acc  = tos;
								tos_n    = nos;
							end
							ascs_pkg::INS_RPUSH: begin
								nxt.rtop = r_inc;
								rs_wr    = '{en: 1'b1, idx: r_inc, data: cur.acc};
							end
							ascs_pkg::INS_RPOP: begin
								nxt.rtop = r_dec;
								nxt.acc  = rs_val;
							end
							ascs_pkg::INS_ADD: begin
								nxt.dtop = d_dec;
								tos_n    = sum;
								ds_wr    = '{en: 1'b1, idx: d_dec, data: sum};
							end
							ascs_pkg::INS_SUB: begin
								nxt.dtop = d_dec;
								tos_n    = diff;
								ds_wr    = '{en: 1'b1, idx: d_dec, data: diff};
							end
							ascs_pkg::INS_LOAD: begin
								nxt.dtop = d_dec;
								tos_n    = nos;
								if (tos_ok) begin
									nxt.acc = load_data;
								end else begin
									nxt.stop = ascs_pkg::ST_LOAD_RANGE;
								end
							end
							ascs_pkg::INS_STOR: begin
								nxt.dtop = d_dec;
								tos_n    = nos;
								if (tos_ok) begin
									core_wr.en   = 1'b1;
									core_wr.idx  = ascs_pkg::core_idx({1'b0, tos});
									core_wr.data = cur.acc;
								end else begin
									nxt.stop = ascs_pkg::ST_STOR_RANGE;
								end
							end
							ascs_pkg::INS_HALT: begin
								nxt.stop = ascs_pkg::ST_HALT;
							end
							default: begin
								nxt.stop = ascs_pkg::ST_BAD_OP;
							end
						endcase
					end
				end
			end
			default: begin
				nxt.pc   = '0;
				nxt.dtop = '0;
				nxt.rtop = '0;
				nxt.acc  = '0;
				nxt.stop = ascs_pkg::ST_RUN;
				tos_n    = ds0;
			end
		endcase
	end

endmodule

FILE: rtl/accumulator_stack_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_step
// byte machine with 64-byte core, data and return stacks and an accumulator.
// Takes one transaction per clock cycle, back to back, while each result is
// taken as it appears; each result passes the input register, then the
// result register, and waits there until it is taken. The output
// register lets the next transaction in while a result waits. The rate is set
// by the single execute step between the two registers: decode of the opcode,
// one stack update and at most one core access. The opcode, a read byte, the
// load operand and the top two data stack entries are fetched as a
// transaction enters, from the machine state that the transaction ahead of it
// leaves. All stores read as zero after reset without a clearing pass.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [5:0] address,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [6:0] program_counter,
	output logic [7:0] accumulator,
	output logic [7:0] read_data
);

	logic                valid_s1;
	ascs_pkg::oper_t     op_s1;
	logic [5:0]          addr_s1;
	logic [7:0]          wdata_s1;

	ascs_pkg::mach_t     mach_q;
	ascs_pkg::mach_t     mach_n;
	logic [7:0]          rs_q [ascs_pkg::RS_DEPTH];

	logic                out_valid_q;
	ascs_pkg::stop_t     status_q;
	logic [6:0]          pc_q;
	logic [7:0]          acc_q;
	logic [7:0]          rdata_q;

	logic                fire;
	logic                in_fire;
	ascs_pkg::oper_t     nxt_op;
	logic [5:0]          nxt_addr;

	ascs_pkg::mach_t     ex_nxt;
	logic [7:0]          ex_tos_n;
	ascs_pkg::core_wr_t  ex_core_wr;
	ascs_pkg::ds_wr_t    ex_ds_wr;
	ascs_pkg::rs_wr_t    ex_rs_wr;
	logic [7:0]          ex_rdata;

	ascs_pkg::core_wr_t  core_wr_g;
	ascs_pkg::ds_wr_t    ds_wr_g;
	logic [7:0]          tos_eff;
	ascs_pkg::core_idx_t ra_idx;
	ascs_pkg::core_idx_t rb_idx;
	logic [7:0]          ra_q;
	logic [7:0]          rb_q;
	logic [7:0]          tos_q;
	logic [7:0]          nos_q;
	logic [7:0]          ds0_q;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign in_fire  = in_valid && in_ready;

	assign nxt_op   = in_fire ? ascs_pkg::oper_t'(operation) : op_s1;
	assign nxt_addr = in_fire ? address : addr_s1;

	assign mach_n    = fire ? ex_nxt : mach_q;
	assign tos_eff   = fire ? ex_tos_n : tos_q;
	assign core_wr_g = fire ? ex_core_wr : '0;
	assign ds_wr_g   = fire ? ex_ds_wr : '0;

	// port a serves the read transaction or the opcode fetch
	assign ra_idx = (nxt_op == ascs_pkg::OP_READ) ? ascs_pkg::core_idx({3'b000, nxt_addr})
		: ascs_pkg::core_idx({2'b00, mach_n.pc});
	assign rb_idx = ascs_pkg::core_idx({1'b0, tos_eff});

	ascs_core_mem u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (core_wr_g),
		.ra_idx (ra_idx),
		.rb_idx (rb_idx),
		.ra_q   (ra_q),
		.rb_q   (rb_q)
	);

	ascs_dstack u_dstack (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ds_wr_g),
		.top_n  (mach_n.dtop),
		.tos_n  (tos_eff),
		.tos_q  (tos_q),
		.nos_q  (nos_q),
		.ds0_q  (ds0_q)
	);

	ascs_exec u_exec (
		.op         (op_s1),
		.addr       (addr_s1),
		.wdata      (wdata_s1),
		.cur        (mach_q),
		.tos        (tos_q),
		.nos        (nos_q),
		.ds0        (ds0_q),
		.rs_val     (rs_q[mach_q.rtop]),
		.fetch_data (ra_q),
		.load_data  (rb_q),
		.nxt        (ex_nxt),
		.tos_n      (ex_tos_n),
		.core_wr    (ex_core_wr),
		.ds_wr      (ex_ds_wr),
		.rs_wr      (ex_rs_wr),
		.rdata      (ex_rdata)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= ascs_pkg::oper_t'(operation);
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	// machine state and return stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mach_q <= '0;
			rs_q   <= '{default: '0};
		end else begin
			mach_q <= mach_n;
			if (fire && ex_rs_wr.en) begin
				rs_q[ex_rs_wr.idx] <= ex_rs_wr.data;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= ex_nxt.stop;
			pc_q     <= ex_nxt.pc;
			acc_q    <= ex_nxt.acc;
			rdata_q  <= ex_rdata;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign program_counter = pc_q;
	assign accumulator     = acc_q;
	assign read_data       = rdata_q;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("executed transaction left no result");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == ascs_pkg::OP_EXEC && mach_q.stop != ascs_pkg::ST_RUN
		|=> $stable(mach_q))
		else $error("stopped machine changed state on execute");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == ascs_pkg::OP_RESTART
		|=> mach_q.pc == '0 && mach_q.dtop == '0 && mach_q.rtop == '0
			&& mach_q.acc == '0 && mach_q.stop == ascs_pkg::ST_RUN)
		else $error("restart left machine state behind");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input register refused a transaction");

endmodule

FILE: verif/ascs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascs_checker
// Watches both channels of the stack machine. Keeps its own copy of the
// core, the two stacks and the machine registers, works out the result of
// every accepted input transaction and compares each accepted output
// transaction with the oldest result still awaited.
// ----------------------------------------------------------------------------
module ascs_checker
	import ascs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] operation,
	input  logic [5:0] address,
	input  logic [7:0] write_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] status,
	input  logic [6:0] program_counter,
	input  logic [7:0] accumulator,
	input  logic [7:0] read_data,
	output int         pending,
	output int         fails
);

	typedef struct packed {
		stop_t      stop;
		logic [6:0] pc;
		logic [7:0] acc;
		logic [7:0] rdata;
	} outcome_t;

	logic [7:0] core_img [CORE_DEPTH];
	logic [7:0] dstk [DS_DEPTH];
	logic [7:0] rstk [RS_DEPTH];
	logic [6:0] pc_q;
	ds_idx_t    dtop_q;
	rs_idx_t    rtop_q;
	logic [7:0] acc_q;
	stop_t      stop_q;

	outcome_t due_q [$];

	task automatic report(input string what);
		fails++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic logic [7:0] ds_take();
		logic [7:0] v;
		v = dstk[dtop_q];
		dtop_q = dtop_q - 1'b1;
		return v;
	endfunction

	task automatic step_machine(input oper_t op, input logic [5:0] addr,
			input logic [7:0] wdata, output outcome_t res);
		logic [7:0] opc;
		logic [7:0] a;
		res.rdata = '0;
		case (op)
		OP_WRITE: core_img[addr] = wdata;
		OP_READ: res.rdata = core_img[addr];
		OP_EXEC: if (stop_q == ST_RUN) begin
			if (pc_q >= CORE_DEPTH) begin
				stop_q = ST_PC_RANGE;
			end else begin
				opc = core_img[pc_q[CORE_AW-1:0]];
				pc_q = pc_q + 1'b1;
				case (opc)
				INS_NOOP: begin
				end
				INS_JMP: begin
					a = ds_take();
					if (a >= CORE_DEPTH) stop_q = ST_JMP_RANGE;
					else pc_q = 7'(a);
				end
				INS_JEQ: begin
					a = ds_take();
					if (acc_q == 8'h00) begin
						if (a >= CORE_DEPTH) stop_q = ST_JEQ_RANGE;
						else pc_q = 7'(a);
					end
				end
				INS_PUSH: begin
					dtop_q = dtop_q + 1'b1;
					dstk[dtop_q] = acc_q;
				end
				INS_POP: acc_q = ds_take();
				INS_RPUSH: begin
					rtop_q = rtop_q + 1'b1;
					rstk[rtop_q] = acc_q;
				end
				INS_RPOP: begin
					acc_q = rstk[rtop_q];
					rtop_q = rtop_q - 1'b1;
				end
				INS_ADD: begin
					a = ds_take();
					dstk[dtop_q] = dstk[dtop_q] + a;
				end
				INS_SUB: begin
					a = ds_take();
					dstk[dtop_q] = dstk[dtop_q] - a;
				end
				INS_LOAD: begin
					a = ds_take();
					if (a >= CORE_DEPTH) stop_q = ST_LOAD_RANGE;
					else acc_q = core_img[a[CORE_AW-1:0]];
				end
				INS_STOR: begin
					a = ds_take();
					if (a >= CORE_DEPTH) stop_q = ST_STOR_RANGE;
					else core_img[a[CORE_AW-1:0]] = acc_q;
				end
				INS_HALT: stop_q = ST_HALT;
				default: stop_q = ST_BAD_OP;
				endcase
			end
		end
		OP_RESTART: begin
			// core and stack contents survive a restart
			pc_q = '0;
			dtop_q = '0;
			rtop_q = '0;
			acc_q = '0;
			stop_q = ST_RUN;
		end
		endcase
		res.stop = stop_q;
		res.pc = pc_q;
		res.acc = acc_q;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < CORE_DEPTH; i++) core_img[i] = '0;
			for (i = 0; i < DS_DEPTH; i++) dstk[i] = '0;
			for (i = 0; i < RS_DEPTH; i++) rstk[i] = '0;
			pc_q = '0;
			dtop_q = '0;
			rtop_q = '0;
			acc_q = '0;
			stop_q = ST_RUN;
			due_q.delete();
			fails = 0;
			pending <= 0;
		end else begin
			// older transaction first: a result can never belong to the same edge's input
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					report($sformatf("result with none awaited: status %0d pc %0d acc %0d rd %0d",
						status, program_counter, accumulator, read_data));
				end else begin
					want = due_q.pop_front();
					if (status !== want.stop || program_counter !== want.pc ||
							accumulator !== want.acc || read_data !== want.rdata)
						report($sformatf({"got status %0d pc %0d acc %0d rd %0d, ",
							"awaited status %0d pc %0d acc %0d rd %0d"},
							status, program_counter, accumulator, read_data,
							want.stop, want.pc, want.acc, want.rdata));
				end
			end
			if (in_valid && in_ready) begin
				step_machine(oper_t'(operation), address, write_data, want);
				due_q.push_back(want);
			end
			pending <= due_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the accumulator stack machine: a short hand-built program
// that walks through halt, panics and restarts, then randomly generated
// programs executed step by step, mixed with core accesses and random
// transactions, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import ascs_pkg::*;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int QUIET_TAIL     = 250;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic [7:0] INS_SET [12] = '{INS_NOOP, INS_JMP, INS_JEQ, INS_PUSH,
		INS_POP, INS_RPUSH, INS_RPOP, INS_ADD, INS_SUB, INS_LOAD, INS_STOR, INS_HALT};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = '0;
	logic [5:0] address = '0;
	logic [7:0] write_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] status;
	logic [6:0] program_counter;
	logic [7:0] accumulator;
	logic [7:0] read_data;

	int pending;
	int fails;
	int sent = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	accumulator_stack_cpu_step uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.address         (address),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.program_counter (program_counter),
		.accumulator     (accumulator),
		.read_data       (read_data)
	);

	ascs_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.address         (address),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.program_counter (program_counter),
		.accumulator     (accumulator),
		.read_data       (read_data),
		.pending         (pending),
		.fails           (fails)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side back-pressure in bursts that start at random
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
			stall_left <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// called at the edge where the previous transaction went through
	task automatic send(input oper_t op, input logic [5:0] addr, input logic [7:0] data);
		int gap;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int episode;
		int len;
		int i;
		logic [7:0] opc;
		episode = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// hand-built program: load a jump target through core, jump to the top byte
		send(OP_READ, 6'd63, 8'h00);
		send(OP_WRITE, 6'd9, 8'd63);
		send(OP_WRITE, 6'd0, INS_LOAD);
		send(OP_WRITE, 6'd1, INS_PUSH);
		send(OP_WRITE, 6'd2, INS_LOAD);
		send(OP_WRITE, 6'd3, INS_PUSH);
		send(OP_WRITE, 6'd4, INS_JMP);
		repeat (5) send(OP_EXEC, 6'd0, 8'h00);
		// noop on the last byte runs the pc off the core, then it stays stopped
		repeat (3) send(OP_EXEC, 6'd63, 8'hff);
		send(OP_READ, 6'd0, 8'hff);
		send(OP_WRITE, 6'd63, INS_HALT);
		send(OP_RESTART, 6'd0, 8'h00);
		send(OP_WRITE, 6'd0, 8'h0b);
		send(OP_EXEC, 6'd0, 8'h00);
		send(OP_RESTART, 6'd63, 8'hff);
		send(OP_WRITE, 6'd0, INS_JMP);
		send(OP_EXEC, 6'd0, 8'h00);
		send(OP_EXEC, 6'd0, 8'h00);
		send(OP_RESTART, 6'd0, 8'h00);
		settle_results();

		while (sent < RANDOM_ITEMS + 25) begin
			episode++;
			if (sent >= RANDOM_ITEMS + 25 - QUIET_TAIL) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end else if (episode % 4 == 1) begin
				case ($urandom_range(3))
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 15; rx_stall_pct = 15; end
				2: begin tx_idle_pct = 50; rx_stall_pct = 10; end
				default: begin tx_idle_pct = 10; rx_stall_pct = 50; end
				endcase
			end
			if (episode % 12 == 0) settle_results();

			if ($urandom_range(99) < 15) begin
				repeat (20) send(oper_t'($urandom_range(3)), 6'($urandom), 8'($urandom));
			end else begin
				send(OP_RESTART, 6'($urandom), 8'($urandom));
				// sometimes rerun what is already in core with the stacks left behind
				if ($urandom_range(3) != 0) begin
					len = $urandom_range(3, 24);
					for (i = 0; i < len; i++) begin
						opc = ($urandom_range(99) < 8) ? 8'($urandom) :
							INS_SET[$urandom_range(11)];
						send(OP_WRITE, 6'(i), opc);
					end
					repeat ($urandom_range(0, 4)) send(OP_WRITE, 6'($urandom), 8'($urandom));
				end
				repeat ($urandom_range(6, 40)) begin
					if ($urandom_range(9) == 0)
						send(oper_t'($urandom_range(1)), 6'($urandom), 8'($urandom));
					else
						send(OP_EXEC, 6'($urandom), 8'($urandom));
				end
			end
		end

		settle_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ascs_pkg.sv
rtl/ascs_core_mem.sv
rtl/ascs_dstack.sv
rtl/ascs_exec.sv
rtl/accumulator_stack_cpu_step.sv
verif/ascs_checker.sv
verif/testbench.sv
